// ===== hw/rtl/x86_16_instruction_decoder_core_assert.svh =====
// Assertion macros used by the decoder core.
// Depends on nothing; included by the decoder core to check its own logic.
`ifndef X86_16_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define X86_16_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define X86D_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define X86D_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/x86d_pkg.sv =====
// Shared types, opcode constants and a helper function of the x86 decoder.
// Depends on nothing; used by every decoder module.
`timescale 1ns / 1ps

package x86d_pkg;

	localparam int BUF_DEPTH = 6;
	localparam int NUM_JUMPS = 20;

	typedef logic [2:0] cnt_t;

	typedef enum logic [3:0] {
		CL_UNSUP,
		CL_JUMP,
		CL_MOVRM,
		CL_ALURM,
		CL_MOVIMMRM,
		CL_ALUIMMRM,
		CL_MOVLOAD,
		CL_MOVSTORE,
		CL_ALUACC,
		CL_MOVIMMREG
	} insn_class_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_REG,
		KIND_BASED,
		KIND_DIRECT,
		KIND_IMM,
		KIND_REL
	} opnd_kind_t;

	localparam logic [4:0] MN_MOV       = 5'd0;
	localparam logic [4:0] MN_ADD       = 5'd1;
	localparam logic [4:0] MN_SUB       = 5'd2;
	localparam logic [4:0] MN_CMP       = 5'd3;
	localparam logic [4:0] MN_JUMP_BASE = 5'd4;
	localparam logic [4:0] MN_UNSUP     = 5'd24;

	// Operation select codes of the arithmetic group.
	localparam logic [2:0] ALU_SEL_ADD = 3'd0;
	localparam logic [2:0] ALU_SEL_SUB = 3'd5;
	localparam logic [2:0] ALU_SEL_CMP = 3'd7;

	localparam logic [1:0] MOD_MEM0 = 2'd0;
	localparam logic [1:0] MOD_MEM8 = 2'd1;
	localparam logic [1:0] MOD_MEM16 = 2'd2;
	localparam logic [1:0] MOD_REG  = 2'd3;
	localparam logic [2:0] RM_DIRECT = 3'd6;

	localparam logic [7:0] OP_SEG_FROM = 8'h8C;
	localparam logic [7:0] OP_SEG_TO   = 8'h8E;

	localparam logic [7:0] MASK_W      = 8'hFE;
	localparam logic [7:0] MASK_DW     = 8'hFC;
	localparam logic [7:0] MASK_HI     = 8'hF0;

	localparam logic [7:0] OP_MOV_IMM_RM = 8'hC6;
	localparam logic [7:0] OP_MOV_LOAD   = 8'hA0;
	localparam logic [7:0] OP_MOV_STORE  = 8'hA2;
	localparam logic [7:0] OP_ADD_ACC    = 8'h04;
	localparam logic [7:0] OP_SUB_ACC    = 8'h2C;
	localparam logic [7:0] OP_CMP_ACC    = 8'h3C;
	localparam logic [7:0] OP_ADD_RM     = 8'h00;
	localparam logic [7:0] OP_SUB_RM     = 8'h28;
	localparam logic [7:0] OP_CMP_RM     = 8'h38;
	localparam logic [7:0] OP_ALU_IMM_RM = 8'h80;
	localparam logic [7:0] OP_MOV_RM     = 8'h88;
	localparam logic [7:0] OP_MOV_IMM_REG = 8'hB0;

	// Short jump and loop opcodes, in mnemonic order.
	localparam logic [7:0] JUMP_CODES [NUM_JUMPS] = '{
		8'h75, 8'h74, 8'h7C, 8'h7E, 8'h72, 8'h76, 8'h7A, 8'h70, 8'h78, 8'h7D,
		8'h7F, 8'h73, 8'h77, 8'h7B, 8'h71, 8'h79, 8'hE2, 8'hE1, 8'hE0, 8'hE3
	};

	typedef struct packed {
		insn_class_t cls;
		logic [4:0]  jump_idx;
	} class_info_t;

	typedef struct packed {
		logic [4:0]  mnemonic;
		logic [2:0]  dest_kind;
		logic [3:0]  dest_reg;
		logic [2:0]  src_kind;
		logic [3:0]  src_reg;
		logic [2:0]  ea_mode;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic        word_size;
	} dec_fields_t;

	// Number of displacement bytes that follow the mod/rm byte.
	function automatic logic [1:0] disp_len(input logic [1:0] md, input logic [2:0] rm);
		logic [1:0] n;
		begin
			unique case (md)
				MOD_MEM0:  n = (rm == RM_DIRECT) ? 2'd2 : 2'd0;
				MOD_MEM8:  n = 2'd1;
				MOD_MEM16: n = 2'd2;
				default:   n = 2'd0;
			endcase
			return n;
		end
	endfunction

endpackage

// ===== hw/rtl/x86_16_instruction_decoder_core.sv =====
// 16-bit x86 instruction decoder, fed one byte per transaction.
// Throughput: one byte per cycle while the input is not stalled, limited by the loop through the byte counter.
// An instruction's last byte waits in the input register; its decode loads the result register when that byte retires.
// While a result is stalled, the following bytes are still absorbed; only the byte that
// completes the next instruction waits in the input register, and the input stalls behind it.
// Reset clears the byte counter and both valid flags; the byte buffer is not reset.
`timescale 1ns / 1ps

module x86_16_instruction_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  mnemonic,
	output logic [2:0]  dest_kind,
	output logic [3:0]  dest_reg,
	output logic [2:0]  src_kind,
	output logic [3:0]  src_reg,
	output logic [2:0]  ea_mode,
	output logic signed [15:0] displacement,
	output logic signed [15:0] immediate,
	output logic        word_size,
	output logic [2:0]  length
);

`include "x86_16_instruction_decoder_core_assert.svh"

	// Input register: one accepted byte waits here for its decode cycle.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Instruction buffer and the count of bytes already held for the
	// current instruction.
	logic [x86d_pkg::BUF_DEPTH-1:0][7:0] buf_q;
	x86d_pkg::cnt_t taken_q;

	// Result register.
	logic                  out_valid_q;
	x86d_pkg::dec_fields_t res_q;
	logic [2:0]            len_q;

	logic [2:0]                          wr_idx;
	x86d_pkg::cnt_t                      taken_new;
	logic [x86d_pkg::BUF_DEPTH-1:0][7:0] eff_bytes;
	x86d_pkg::class_info_t               info;
	x86d_pkg::cnt_t                      need;
	logic                                done;
	x86d_pkg::dec_fields_t               fields;
	logic                                out_free;
	logic                                fire_s1;
	logic                                load_s1;

	// The byte in the input register lands at the next free slot; a count past
	// the buffer depth would restart it, which no legal instruction reaches.
	always_comb begin
		wr_idx    = (taken_q > 3'(x86d_pkg::BUF_DEPTH - 1)) ? 3'd0 : taken_q;
		taken_new = wr_idx + 3'd1;
		for (int i = 0; i < x86d_pkg::BUF_DEPTH; i++) begin
			eff_bytes[i] = (wr_idx == 3'(i)) ? byte_s1 : buf_q[i];
		end
	end

	x86d_len u_len (
		.op    (eff_bytes[0]),
		.modrm (eff_bytes[1]),
		.taken (taken_new),
		.info  (info),
		.need  (need),
		.done  (done)
	);

	x86d_fields u_fields (
		.insn_bytes (eff_bytes),
		.info       (info),
		.fields     (fields)
	);

	// A byte that completes an instruction may only retire when the result
	// register is free or draining this cycle; any other byte retires at once.
	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && (!done || out_free);
	assign load_s1  = !valid_s1 || fire_s1;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (fire_s1) begin
			taken_q <= done ? 3'd0 : taken_new;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			buf_q[wr_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && done) begin
			res_q <= fields;
			len_q <= need;
		end
	end

	assign out_valid    = out_valid_q;
	assign mnemonic     = res_q.mnemonic;
	assign dest_kind    = res_q.dest_kind;
	assign dest_reg     = res_q.dest_reg;
	assign src_kind     = res_q.src_kind;
	assign src_reg      = res_q.src_reg;
	assign ea_mode      = res_q.ea_mode;
	assign displacement = res_q.displacement;
	assign immediate    = res_q.immediate;
	assign word_size    = res_q.word_size;
	assign length       = len_q;

	// The counter never holds a full buffer between instructions.
	`X86D_ASSERT_NOW(a_taken_range, clk, arst_n, 1'b1, taken_q < 3'(x86d_pkg::BUF_DEPTH), "byte count out of range")

	// A completed instruction produces a result and restarts the buffer.
	`X86D_ASSERT_NEXT(a_done_emits, clk, arst_n, fire_s1 && done, out_valid_q && taken_q == 3'd0, "completed instruction not emitted")

	// A partial instruction advances the count by exactly one byte.
	`X86D_ASSERT_NEXT(a_partial_count, clk, arst_n, fire_s1 && !done, taken_q == $past(taken_new) && !$rose(out_valid_q), "partial instruction miscounted")

	// A completion never overwrites a result that is still being held.
	`X86D_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && out_stall && valid_s1 && done, in_stall && !fire_s1, "held result overwritten")

	// Every emitted result carries a legal length.
	`X86D_ASSERT_NOW(a_len_legal, clk, arst_n, out_valid_q, len_q != 3'd0 && len_q <= 3'(x86d_pkg::BUF_DEPTH), "illegal instruction length")

endmodule

// ===== hw/rtl/x86d_len.sv =====
// Opcode classification and instruction length from the first two bytes.
// Depends on x86d_pkg.
`timescale 1ns / 1ps

module x86d_len (
	input  logic [7:0]           op,
	input  logic [7:0]           modrm,
	input  x86d_pkg::cnt_t       taken,
	output x86d_pkg::class_info_t info,
	output x86d_pkg::cnt_t       need,
	output logic                 done
);

	logic       jump_hit;
	logic [4:0] jump_idx;
	logic       has_modrm;
	logic [1:0] dl;
	logic [1:0] il;

	// The jump table holds distinct codes, so at most one compare hits.
	always_comb begin
		jump_hit = 1'b0;
		jump_idx = '0;
		for (int i = 0; i < x86d_pkg::NUM_JUMPS; i++) begin
			if (op == x86d_pkg::JUMP_CODES[i]) begin
				jump_hit = 1'b1;
				jump_idx = 5'(i);
			end
		end
	end

	always_comb begin
		info.jump_idx = jump_idx;
		if (jump_hit) begin
			info.cls = x86d_pkg::CL_JUMP;
		end else if (op == x86d_pkg::OP_SEG_FROM || op == x86d_pkg::OP_SEG_TO) begin
			info.cls = x86d_pkg::CL_UNSUP;
		end else if ((op & x86d_pkg::MASK_W) == x86d_pkg::OP_MOV_IMM_RM) begin
			info.cls = x86d_pkg::CL_MOVIMMRM;
		end else if ((op & x86d_pkg::MASK_W) == x86d_pkg::OP_MOV_LOAD) begin
			info.cls = x86d_pkg::CL_MOVLOAD;
		end else if ((op & x86d_pkg::MASK_W) == x86d_pkg::OP_MOV_STORE) begin
			info.cls = x86d_pkg::CL_MOVSTORE;
		end else if ((op & x86d_pkg::MASK_W) == x86d_pkg::OP_ADD_ACC
				|| (op & x86d_pkg::MASK_W) == x86d_pkg::OP_SUB_ACC
				|| (op & x86d_pkg::MASK_W) == x86d_pkg::OP_CMP_ACC) begin
			info.cls = x86d_pkg::CL_ALUACC;
		end else if ((op & x86d_pkg::MASK_DW) == x86d_pkg::OP_ADD_RM
				|| (op & x86d_pkg::MASK_DW) == x86d_pkg::OP_SUB_RM
				|| (op & x86d_pkg::MASK_DW) == x86d_pkg::OP_CMP_RM) begin
			info.cls = x86d_pkg::CL_ALURM;
		end else if ((op & x86d_pkg::MASK_DW) == x86d_pkg::OP_ALU_IMM_RM) begin
			info.cls = x86d_pkg::CL_ALUIMMRM;
		end else if ((op & x86d_pkg::MASK_DW) == x86d_pkg::OP_MOV_RM) begin
			info.cls = x86d_pkg::CL_MOVRM;
		end else if ((op & x86d_pkg::MASK_HI) == x86d_pkg::OP_MOV_IMM_REG) begin
			info.cls = x86d_pkg::CL_MOVIMMREG;
		end else begin
			info.cls = x86d_pkg::CL_UNSUP;
		end
	end

	always_comb begin
		has_modrm = (info.cls == x86d_pkg::CL_MOVRM) || (info.cls == x86d_pkg::CL_ALURM)
			|| (info.cls == x86d_pkg::CL_MOVIMMRM) || (info.cls == x86d_pkg::CL_ALUIMMRM);
		dl = x86d_pkg::disp_len(modrm[7:6], modrm[2:0]);
		unique case (info.cls)
			x86d_pkg::CL_JUMP:      il = 2'd1;
			x86d_pkg::CL_MOVIMMRM,
			x86d_pkg::CL_ALUACC:    il = op[0] ? 2'd2 : 2'd1;
			x86d_pkg::CL_ALUIMMRM:  il = (op[0] && !op[1]) ? 2'd2 : 2'd1;
			x86d_pkg::CL_MOVLOAD,
			x86d_pkg::CL_MOVSTORE:  il = 2'd2;
			x86d_pkg::CL_MOVIMMREG: il = op[3] ? 2'd2 : 2'd1;
			default:                il = 2'd0;
		endcase

		if (info.cls == x86d_pkg::CL_UNSUP) begin
			need = 3'd1;
		end else if (has_modrm && taken < 3'd2) begin
			// Length is open until the mod/rm byte is in.
			need = 3'd2;
		end else if (has_modrm) begin
			need = 3'd2 + {1'b0, dl} + {1'b0, il};
		end else begin
			need = 3'd1 + {1'b0, il};
		end
		done = (taken >= need);
	end

endmodule

// ===== hw/rtl/x86d_fields.sv =====
// Operand and mnemonic field decode of one complete buffered instruction.
// Depends on x86d_pkg.
`timescale 1ns / 1ps

module x86d_fields (
	input  logic [x86d_pkg::BUF_DEPTH-1:0][7:0] insn_bytes,
	input  x86d_pkg::class_info_t               info,
	output x86d_pkg::dec_fields_t               fields
);

	function automatic logic [15:0] sext8(input logic [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

	function automatic logic [4:0] alu_code(input logic [2:0] sel);
		logic [4:0] mn;
		begin
			unique case (sel)
				x86d_pkg::ALU_SEL_ADD: mn = x86d_pkg::MN_ADD;
				x86d_pkg::ALU_SEL_SUB: mn = x86d_pkg::MN_SUB;
				x86d_pkg::ALU_SEL_CMP: mn = x86d_pkg::MN_CMP;
				default:               mn = x86d_pkg::MN_UNSUP;
			endcase
			return mn;
		end
	endfunction

	logic [7:0]  op;
	logic [7:0]  m;
	logic        w;
	logic [1:0]  md;
	logic [2:0]  rm;
	logic [2:0]  regf;
	logic [1:0]  dl;
	logic [7:0]  imm_lo;
	logic [7:0]  imm_hi;
	logic [15:0] imm_rm;
	logic [2:0]  rm_kind;
	logic [3:0]  rm_reg;
	logic [2:0]  rm_ea;
	logic [15:0] rm_disp;
	x86d_pkg::dec_fields_t f;

	assign op   = insn_bytes[0];
	assign m    = insn_bytes[1];
	assign w    = op[0];
	assign md   = m[7:6];
	assign rm   = m[2:0];
	assign regf = m[5:3];
	assign dl   = x86d_pkg::disp_len(md, rm);

	// Immediate of the reg/mem immediate forms sits right after the displacement.
	always_comb begin
		unique case (dl)
			2'd0:    begin imm_lo = insn_bytes[2]; imm_hi = insn_bytes[3]; end
			2'd1:    begin imm_lo = insn_bytes[3]; imm_hi = insn_bytes[4]; end
			default: begin imm_lo = insn_bytes[4]; imm_hi = insn_bytes[5]; end
		endcase
		if (info.cls == x86d_pkg::CL_MOVIMMRM) begin
			imm_rm = w ? {imm_hi, imm_lo} : sext8(imm_lo);
		end else begin
			imm_rm = (w && !op[1]) ? {imm_hi, imm_lo} : sext8(imm_lo);
		end
	end

	// Operand named by mod and rm.
	always_comb begin
		rm_kind = x86d_pkg::KIND_BASED;
		rm_reg  = '0;
		rm_ea   = '0;
		rm_disp = '0;
		if (md == x86d_pkg::MOD_REG) begin
			rm_kind = x86d_pkg::KIND_REG;
			rm_reg  = {w, rm};
		end else if (md == x86d_pkg::MOD_MEM0 && rm == x86d_pkg::RM_DIRECT) begin
			rm_kind = x86d_pkg::KIND_DIRECT;
			rm_disp = {insn_bytes[3], insn_bytes[2]};
		end else begin
			rm_ea = rm;
			if (md == x86d_pkg::MOD_MEM8) begin
				rm_disp = sext8(insn_bytes[2]);
			end else if (md == x86d_pkg::MOD_MEM16) begin
				rm_disp = {insn_bytes[3], insn_bytes[2]};
			end
		end
	end

	always_comb begin
		f = '0;
		f.mnemonic = x86d_pkg::MN_UNSUP;
		unique case (info.cls)
			x86d_pkg::CL_JUMP: begin
				f.mnemonic  = x86d_pkg::MN_JUMP_BASE + info.jump_idx;
				f.dest_kind = x86d_pkg::KIND_REL;
				f.immediate = sext8(insn_bytes[1]);
			end
			x86d_pkg::CL_MOVRM, x86d_pkg::CL_ALURM: begin
				f.mnemonic  = (info.cls == x86d_pkg::CL_MOVRM) ? x86d_pkg::MN_MOV
					: alu_code(op[5:3]);
				f.word_size    = w;
				f.ea_mode      = rm_ea;
				f.displacement = rm_disp;
				if (op[1]) begin
					f.dest_kind = x86d_pkg::KIND_REG;
					f.dest_reg  = {w, regf};
					f.src_kind  = rm_kind;
					f.src_reg   = rm_reg;
				end else begin
					f.src_kind  = x86d_pkg::KIND_REG;
					f.src_reg   = {w, regf};
					f.dest_kind = rm_kind;
					f.dest_reg  = rm_reg;
				end
			end
			x86d_pkg::CL_MOVIMMRM, x86d_pkg::CL_ALUIMMRM: begin
				f.mnemonic  = (info.cls == x86d_pkg::CL_MOVIMMRM) ? x86d_pkg::MN_MOV
					: alu_code(regf);
				f.word_size    = w;
				f.dest_kind    = rm_kind;
				f.dest_reg     = rm_reg;
				f.ea_mode      = rm_ea;
				f.displacement = rm_disp;
				f.src_kind     = x86d_pkg::KIND_IMM;
				f.immediate    = imm_rm;
			end
			x86d_pkg::CL_MOVLOAD: begin
				f.mnemonic     = x86d_pkg::MN_MOV;
				f.word_size    = w;
				f.dest_kind    = x86d_pkg::KIND_REG;
				f.dest_reg     = {w, 3'd0};
				f.src_kind     = x86d_pkg::KIND_DIRECT;
				f.displacement = {insn_bytes[2], insn_bytes[1]};
			end
			x86d_pkg::CL_MOVSTORE: begin
				f.mnemonic     = x86d_pkg::MN_MOV;
				f.word_size    = w;
				f.src_kind     = x86d_pkg::KIND_REG;
				f.src_reg      = {w, 3'd0};
				f.dest_kind    = x86d_pkg::KIND_DIRECT;
				f.displacement = {insn_bytes[2], insn_bytes[1]};
			end
			x86d_pkg::CL_ALUACC: begin
				f.mnemonic  = alu_code(op[5:3]);
				f.word_size = w;
				f.dest_kind = x86d_pkg::KIND_REG;
				f.dest_reg  = {w, 3'd0};
				f.src_kind  = x86d_pkg::KIND_IMM;
				f.immediate = w ? {insn_bytes[2], insn_bytes[1]} : sext8(insn_bytes[1]);
			end
			x86d_pkg::CL_MOVIMMREG: begin
				f.mnemonic  = x86d_pkg::MN_MOV;
				f.word_size = op[3];
				f.dest_kind = x86d_pkg::KIND_REG;
				f.dest_reg  = {op[3], op[2:0]};
				f.src_kind  = x86d_pkg::KIND_IMM;
				f.immediate = op[3] ? {insn_bytes[2], insn_bytes[1]} : sext8(insn_bytes[1]);
			end
			default: begin
				f.mnemonic = x86d_pkg::MN_UNSUP;
			end
		endcase
	end

	// An unsupported instruction reports nothing but its mnemonic.
	always_comb begin
		if (f.mnemonic == x86d_pkg::MN_UNSUP) begin
			fields = '0;
			fields.mnemonic = x86d_pkg::MN_UNSUP;
		end else begin
			fields = f;
		end
	end

endmodule

// ===== dv/x86d_decode_checker.sv =====
// Checker for the x86 decoder: watches both channels, predicts each decoded instruction.
// Depends on x86d_pkg for class, kind and opcode constants; instantiated by tb.
`timescale 1ns / 1ps

module x86d_decode_checker
	import x86d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         byte_in,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [4:0]         mnemonic,
	input  logic [2:0]         dest_kind,
	input  logic [3:0]         dest_reg,
	input  logic [2:0]         src_kind,
	input  logic [3:0]         src_reg,
	input  logic [2:0]         ea_mode,
	input  logic signed [15:0] displacement,
	input  logic signed [15:0] immediate,
	input  logic               word_size,
	input  logic [2:0]         length,
	output int                 mismatch_count,
	output int                 insns_outstanding
);

	typedef struct packed {
		dec_fields_t f;
		logic [2:0]  len;
	} decoded_insn_t;

	decoded_insn_t expected_insns [$];
	logic [7:0]    insn_bytes [BUF_DEPTH];
	int            bytes_held = 0;
	int            mismatches = 0;
	int            results_seen = 0;

	function automatic insn_class_t classify_opcode(input logic [7:0] op,
		output logic [4:0] jump_no);
		jump_no = '0;
		for (int i = 0; i < NUM_JUMPS; i++) begin
			if (JUMP_CODES[i] == op) begin
				jump_no = i[4:0];
				return CL_JUMP;
			end
		end
		if (op == OP_SEG_FROM || op == OP_SEG_TO)
			return CL_UNSUP;
		case (op & MASK_W)
			OP_MOV_IMM_RM: return CL_MOVIMMRM;
			OP_MOV_LOAD: return CL_MOVLOAD;
			OP_MOV_STORE: return CL_MOVSTORE;
			OP_ADD_ACC, OP_SUB_ACC, OP_CMP_ACC: return CL_ALUACC;
			default: ;
		endcase
		case (op & MASK_DW)
			OP_ADD_RM, OP_SUB_RM, OP_CMP_RM: return CL_ALURM;
			OP_ALU_IMM_RM: return CL_ALUIMMRM;
			OP_MOV_RM: return CL_MOVRM;
			default: ;
		endcase
		if ((op & MASK_HI) == OP_MOV_IMM_REG)
			return CL_MOVIMMREG;
		return CL_UNSUP;
	endfunction

	function automatic int disp_bytes(input logic [7:0] modrm);
		case (modrm[7:6])
			MOD_MEM0: return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
			MOD_MEM8: return 1;
			MOD_MEM16: return 2;
			default: return 0;
		endcase
	endfunction

	function automatic int imm_bytes(input insn_class_t cls, input logic [7:0] op);
		case (cls)
			CL_JUMP: return 1;
			CL_MOVIMMRM, CL_ALUACC: return op[0] ? 2 : 1;
			CL_ALUIMMRM: return (op[0] && !op[1]) ? 2 : 1;
			CL_MOVLOAD, CL_MOVSTORE: return 2;
			CL_MOVIMMREG: return op[3] ? 2 : 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic has_modrm(input insn_class_t cls);
		return cls inside {CL_MOVRM, CL_ALURM, CL_MOVIMMRM, CL_ALUIMMRM};
	endfunction

	// While the mod/rm byte is still due the length is known to be at least 2.
	function automatic int bytes_needed(input insn_class_t cls, input int held);
		if (cls == CL_UNSUP)
			return 1;
		if (has_modrm(cls)) begin
			if (held < 2)
				return 2;
			return 2 + disp_bytes(insn_bytes[1]) + imm_bytes(cls, insn_bytes[0]);
		end
		return 1 + imm_bytes(cls, insn_bytes[0]);
	endfunction

	// Little-endian value of one or two buffered bytes, sign-extended when one byte.
	function automatic logic [15:0] fetch_value(input int pos, input int n);
		logic [7:0] lo;
		lo = insn_bytes[pos % BUF_DEPTH];
		if (n == 2)
			return {insn_bytes[(pos + 1) % BUF_DEPTH], lo};
		return {{8{lo[7]}}, lo};
	endfunction

	function automatic logic [4:0] alu_mnemonic(input logic [2:0] sel);
		case (sel)
			ALU_SEL_ADD: return MN_ADD;
			ALU_SEL_SUB: return MN_SUB;
			ALU_SEL_CMP: return MN_CMP;
			default: return MN_UNSUP;
		endcase
	endfunction

	function automatic void rm_operand(input logic w, output logic [2:0] kind,
		output logic [3:0] rg, output logic [2:0] ea, output logic [15:0] disp);
		logic [7:0] m;
		m = insn_bytes[1];
		kind = KIND_NONE;
		rg = '0;
		ea = '0;
		disp = '0;
		if (m[7:6] == MOD_REG) begin
			kind = KIND_REG;
			rg = {w, m[2:0]};
		end else if (m[7:6] == MOD_MEM0 && m[2:0] == RM_DIRECT) begin
			kind = KIND_DIRECT;
			disp = fetch_value(2, 2);
		end else begin
			kind = KIND_BASED;
			ea = m[2:0];
			if (m[7:6] != MOD_MEM0)
				disp = fetch_value(2, (m[7:6] == MOD_MEM8) ? 1 : 2);
		end
	endfunction

	// Buffers one accepted byte and queues the decoded instruction once it is complete.
	function automatic void absorb_byte(input logic [7:0] b);
		decoded_insn_t r;
		insn_class_t   cls;
		logic [4:0]    jump_no;
		logic [7:0]    op, m;
		logic          w;
		logic [2:0]    rk;
		logic [3:0]    rr;
		int            need;
		if (bytes_held > BUF_DEPTH - 1)
			bytes_held = 0;
		insn_bytes[bytes_held] = b;
		bytes_held++;
		op = insn_bytes[0];
		cls = classify_opcode(op, jump_no);
		need = bytes_needed(cls, bytes_held);
		if (bytes_held < need)
			return;

		r = '0;
		r.f.mnemonic = MN_UNSUP;
		w = op[0];
		m = insn_bytes[1];
		case (cls)
			CL_JUMP: begin
				r.f.mnemonic = MN_JUMP_BASE + jump_no;
				r.f.dest_kind = KIND_REL;
				r.f.immediate = fetch_value(1, 1);
			end
			CL_MOVRM, CL_ALURM: begin
				r.f.mnemonic = (cls == CL_MOVRM) ? MN_MOV : alu_mnemonic(op[5:3]);
				r.f.word_size = w;
				rm_operand(w, rk, rr, r.f.ea_mode, r.f.displacement);
				if (op[1]) begin
					r.f.dest_kind = KIND_REG;
					r.f.dest_reg = {w, m[5:3]};
					r.f.src_kind = rk;
					r.f.src_reg = rr;
				end else begin
					r.f.src_kind = KIND_REG;
					r.f.src_reg = {w, m[5:3]};
					r.f.dest_kind = rk;
					r.f.dest_reg = rr;
				end
			end
			CL_MOVIMMRM, CL_ALUIMMRM: begin
				r.f.mnemonic = (cls == CL_MOVIMMRM) ? MN_MOV : alu_mnemonic(m[5:3]);
				r.f.word_size = w;
				rm_operand(w, r.f.dest_kind, r.f.dest_reg, r.f.ea_mode, r.f.displacement);
				r.f.src_kind = KIND_IMM;
				r.f.immediate = fetch_value(2 + disp_bytes(m), imm_bytes(cls, op));
			end
			CL_MOVLOAD: begin
				r.f.mnemonic = MN_MOV;
				r.f.word_size = w;
				r.f.dest_kind = KIND_REG;
				r.f.dest_reg = {w, 3'b000};
				r.f.src_kind = KIND_DIRECT;
				r.f.displacement = fetch_value(1, 2);
			end
			CL_MOVSTORE: begin
				r.f.mnemonic = MN_MOV;
				r.f.word_size = w;
				r.f.src_kind = KIND_REG;
				r.f.src_reg = {w, 3'b000};
				r.f.dest_kind = KIND_DIRECT;
				r.f.displacement = fetch_value(1, 2);
			end
			CL_ALUACC: begin
				r.f.mnemonic = alu_mnemonic(op[5:3]);
				r.f.word_size = w;
				r.f.dest_kind = KIND_REG;
				r.f.dest_reg = {w, 3'b000};
				r.f.src_kind = KIND_IMM;
				r.f.immediate = fetch_value(1, w ? 2 : 1);
			end
			CL_MOVIMMREG: begin
				w = op[3];
				r.f.mnemonic = MN_MOV;
				r.f.word_size = w;
				r.f.dest_kind = KIND_REG;
				r.f.dest_reg = {w, op[2:0]};
				r.f.src_kind = KIND_IMM;
				r.f.immediate = fetch_value(1, w ? 2 : 1);
			end
			default: ;
		endcase
		// An unsupported instruction carries nothing but its mnemonic and length.
		if (r.f.mnemonic == MN_UNSUP) begin
			r.f = '0;
			r.f.mnemonic = MN_UNSUP;
		end
		r.len = need[2:0];
		expected_insns.push_back(r);
		bytes_held = 0;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report($sformatf("insn %0d %s: got 0x%0h, expected 0x%0h",
				results_seen, name, got, want));
	endtask

	task automatic check_result();
		decoded_insn_t want;
		results_seen++;
		if (expected_insns.size() == 0) begin
			report($sformatf("insn %0d: unexpected result, mnemonic %0d length %0d",
				results_seen, mnemonic, length));
			return;
		end
		want = expected_insns.pop_front();
		check_field("mnemonic", 16'(mnemonic), 16'(want.f.mnemonic));
		check_field("dest_kind", 16'(dest_kind), 16'(want.f.dest_kind));
		check_field("dest_reg", 16'(dest_reg), 16'(want.f.dest_reg));
		check_field("src_kind", 16'(src_kind), 16'(want.f.src_kind));
		check_field("src_reg", 16'(src_reg), 16'(want.f.src_reg));
		check_field("ea_mode", 16'(ea_mode), 16'(want.f.ea_mode));
		check_field("displacement", displacement, want.f.displacement);
		check_field("immediate", immediate, want.f.immediate);
		check_field("word_size", 16'(word_size), 16'(want.f.word_size));
		check_field("length", 16'(length), 16'(want.len));
	endtask

	// Results are checked before the byte of the same edge is absorbed: a result
	// that leaves at this edge always stems from bytes accepted earlier.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_held = 0;
			expected_insns.delete();
			insns_outstanding <= 0;
			mismatch_count <= mismatches;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				absorb_byte(byte_in);
			insns_outstanding <= expected_insns.size();
			mismatch_count <= mismatches;
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for x86_16_instruction_decoder_core: clock, reset, byte stimulus and verdict.
// Depends on x86d_pkg, the decoder RTL and x86d_decode_checker, which does all checking.
`timescale 1ns / 1ps

module tb;
	import x86d_pkg::*;

	localparam int RANDOM_BYTES = 1270;
	localparam int CYCLE_LIMIT = 200000;
	// The receiver stalls for this long once, after this many results.
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_OFF_AT = 60;
	// Cycles waited after the checker's queue of expected results empties, before the verdict.
	localparam int DRAIN_CYCLES = 16;

	localparam logic [7:0] ALU_RM_OPS [3] = '{OP_ADD_RM, OP_SUB_RM, OP_CMP_RM};
	localparam logic [7:0] ALU_ACC_OPS [3] = '{OP_ADD_ACC, OP_SUB_ACC, OP_CMP_ACC};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] byte_in = '0;
	logic out_stall = 1'b0;

	logic in_stall;
	logic out_valid;
	logic [4:0] mnemonic;
	logic [2:0] dest_kind;
	logic [3:0] dest_reg;
	logic [2:0] src_kind;
	logic [3:0] src_reg;
	logic [2:0] ea_mode;
	logic signed [15:0] displacement;
	logic signed [15:0] immediate;
	logic word_size;
	logic [2:0] length;

	int fail_count;
	int insns_outstanding;
	int cycle_count = 0;
	int bytes_sent = 0;
	int results_taken = 0;

	x86_16_instruction_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mnemonic(mnemonic),
		.dest_kind(dest_kind),
		.dest_reg(dest_reg),
		.src_kind(src_kind),
		.src_reg(src_reg),
		.ea_mode(ea_mode),
		.displacement(displacement),
		.immediate(immediate),
		.word_size(word_size),
		.length(length)
	);

	x86d_decode_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mnemonic(mnemonic),
		.dest_kind(dest_kind),
		.dest_reg(dest_reg),
		.src_kind(src_kind),
		.src_reg(src_reg),
		.ea_mode(ea_mode),
		.displacement(displacement),
		.immediate(immediate),
		.word_size(word_size),
		.length(length),
		.mismatch_count(fail_count),
		.insns_outstanding(insns_outstanding)
	);

	// 12 ns clock period.
	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Sends one byte as a single transaction. Before it, the sender may idle for a
	// random gap, except in every fifth block of 80 bytes, where bytes go
	// back to back. Valid is only lowered when a gap follows, so a byte that comes
	// right after the previous one keeps valid high through the edge. Stall is
	// sampled as it stood before the edge, which is the value the block acted on.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = ((bytes_sent / 80) % 5 == 2) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Sends one well-formed instruction of a random class with random operand
	// bytes. The mod/rm byte is fully random, so every addressing mode and every
	// operation of the immediate group shows up, including the ones that decode as
	// unsupported. One instruction in ten is replaced by a lone random byte, which
	// may start an instruction that then swallows bytes of the ones after it.
	task automatic send_random_insn();
		insn_class_t cls;
		logic [7:0]  op, modrm;
		logic [1:0]  dw, md;
		int          disp_n, imm_n;
		if ($urandom_range(0, 9) == 0) begin
			send_byte(8'($urandom_range(0, 255)));
			return;
		end
		cls = insn_class_t'($urandom_range(0, int'(CL_MOVIMMREG)));
		dw = 2'($urandom_range(0, 3));
		modrm = 8'($urandom_range(0, 255));
		md = modrm[7:6];
		if (md == MOD_MEM8)
			disp_n = 1;
		else if (md == MOD_MEM16 || (md == MOD_MEM0 && modrm[2:0] == RM_DIRECT))
			disp_n = 2;
		else
			disp_n = 0;
		imm_n = 0;
		case (cls)
			CL_JUMP: begin
				op = JUMP_CODES[$urandom_range(0, NUM_JUMPS - 1)];
				imm_n = 1;
			end
			CL_MOVRM: op = OP_MOV_RM | {6'b0, dw};
			CL_ALURM: op = ALU_RM_OPS[$urandom_range(0, 2)] | {6'b0, dw};
			CL_MOVIMMRM: begin
				op = OP_MOV_IMM_RM | {7'b0, dw[0]};
				imm_n = dw[0] ? 2 : 1;
			end
			CL_ALUIMMRM: begin
				// Only the word form without sign extension takes a 16-bit immediate.
				op = OP_ALU_IMM_RM | {6'b0, dw};
				imm_n = (dw[0] && !dw[1]) ? 2 : 1;
			end
			CL_MOVLOAD: begin
				op = OP_MOV_LOAD | {7'b0, dw[0]};
				imm_n = 2;
			end
			CL_MOVSTORE: begin
				op = OP_MOV_STORE | {7'b0, dw[0]};
				imm_n = 2;
			end
			CL_ALUACC: begin
				op = ALU_ACC_OPS[$urandom_range(0, 2)] | {7'b0, dw[0]};
				imm_n = dw[0] ? 2 : 1;
			end
			CL_MOVIMMREG: begin
				op = OP_MOV_IMM_REG | {4'b0, dw[0], modrm[2:0]};
				imm_n = dw[0] ? 2 : 1;
			end
			default: op = dw[0] ? OP_SEG_FROM : OP_SEG_TO;
		endcase
		send_byte(op);
		if (cls inside {CL_MOVRM, CL_ALURM, CL_MOVIMMRM, CL_ALUIMMRM}) begin
			send_byte(modrm);
			imm_n += disp_n;
		end
		repeat (imm_n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// Receiver: before each result it may stall at random, except in every fourth
	// block of 64 results, which goes without any stall. Once, after HOLD_OFF_AT
	// results, it stalls for HOLD_OFF_CYCLES while the sender keeps offering
	// bytes, so the output register fills, the next instruction backs up behind
	// it and the decoder has to stall its input.
	initial begin : receiver
		int hold;
		forever begin
			if (results_taken == HOLD_OFF_AT)
				hold = HOLD_OFF_CYCLES;
			else if ((results_taken / 64) % 4 == 1)
				hold = 0;
			else
				hold = $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			results_taken++;
		end
	end

	initial begin : stimulus
		logic [7:0] directed_stream [$];
		int         random_start;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed machine code. Each line is one instruction unless noted.
		directed_stream = '{
			8'h8C, 8'h8E, 8'hF4,                   // two segment movs, an unknown opcode
			8'h89, 8'hD8,                          // mov ax, bx
			8'h8A, 8'h00,                          // mov al, [bx+si]
			8'h88, 8'h47, 8'h80,                   // mov [bx-128], al
			8'h8B, 8'h86, 8'hFF, 8'h7F,            // mov ax, [bp+7fffh]
			8'h8B, 8'h1E, 8'h34, 8'h12,            // mov bx, [1234h]
			8'hC7, 8'h86, 8'h00, 8'h80, 8'hFF, 8'hFF, // mov word [bp-8000h], 0ffffh
			8'hC6, 8'h06, 8'h10, 8'h00, 8'h7F,     // mov byte [0010h], 7fh
			8'hC6, 8'hC3, 8'h80,                   // mov bl, 80h (register taken from rm)
			8'hB0, 8'hFF,                          // mov al, 0ffh
			8'hBF, 8'h00, 8'h80,                   // mov di, 8000h
			8'hA0, 8'hFF, 8'hFF,                   // mov al, [0ffffh]
			8'hA3, 8'h78, 8'h56,                   // mov [5678h], ax
			8'h00, 8'hC0,                          // add al, al
			8'h2B, 8'h00,                          // sub ax, [bx+si]
			8'h39, 8'hD9,                          // cmp cx, bx
			8'h80, 8'hC1, 8'h7F,                   // add cl, 7fh
			8'h81, 8'hEE, 8'hFF, 8'hFF,            // sub si, 0ffffh
			8'h83, 8'h3E, 8'h00, 8'h10, 8'h80,     // cmp word [1000h], -128
			8'h82, 8'hE8, 8'h01,                   // sub al, 1 in the sign-extended form
			8'h80, 8'hD0, 8'h05,                   // adc: unsupported, whole length
			8'h81, 8'hA7, 8'h00, 8'h01, 8'h02, 8'h03, // and: unsupported, six bytes
			8'h04, 8'h80,                          // add al, -128
			8'h05, 8'hFF, 8'h7F,                   // add ax, 7fffh
			8'h2C, 8'h01,                          // sub al, 1
			8'h2D, 8'h00, 8'h80,                   // sub ax, 8000h
			8'h3C, 8'h00,                          // cmp al, 0
			8'h3D, 8'hFF, 8'hFF                    // cmp ax, 0ffffh
		};
		foreach (directed_stream[i])
			send_byte(directed_stream[i]);

		// Every short jump and loop, alternating the two extreme offsets.
		for (int j = 0; j < NUM_JUMPS; j++) begin
			send_byte(JUMP_CODES[j]);
			send_byte(j[0] ? 8'h80 : 8'h7F);
		end

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES)
			send_random_insn();
		in_valid <= 1'b0;

		// Let the checker see the last accepted byte before reading its count.
		@(posedge clk);
		while (insns_outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && insns_outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
